/* rtl/cdcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CFPQ delta closure step: shared types and constants
// Widths, command and witness codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cdcs_pkg;

    localparam int NT_W      = 4;
    localparam int V_W       = 5;
    localparam int NUM_V     = 32;
    localparam int MAX_RULES = 64;
    localparam int SLOT_W    = 6;
    localparam int RCNT_W    = 7;
    localparam int ROW_AW    = NT_W + V_W;
    localparam int CELL_AW   = NT_W + V_W + V_W;

    localparam logic [RCNT_W-1:0] RULES_MAX = RCNT_W'(MAX_RULES);

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] WK_UNSET   = 2'd0;
    localparam logic [1:0] WK_TERM    = 2'd1;
    localparam logic [1:0] WK_DERIVED = 2'd2;

    typedef struct packed {
        logic [NT_W-1:0] second;
        logic [NT_W-1:0] first;
        logic [V_W-1:0]  mid;
        logic [1:0]      kind;
    } wit_t;

    typedef struct packed {
        logic [NT_W-1:0] left;
        logic [NT_W-1:0] first;
        logic [NT_W-1:0] second;
    } rule_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLEAR, OP_ACCEPT, OP_CELL_RD, OP_CELL_USE,
        OP_COPY_RD, OP_COPY_WR, OP_RULE_RD, OP_ROW_RD, OP_ROW_LATCH,
        OP_S_RD, OP_S_ACC, OP_W_RD, OP_W_WR, OP_MRG_RD, OP_MRG_WR,
        OP_SCAN_RD, OP_SCAN_ACC, OP_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [V_W-1:0]      row;
        logic [V_W-1:0]      mid;
        logic [V_W-1:0]      col;
        logic [SLOT_W-1:0]   rule_addr;
        logic [ROW_AW-1:0]   scan;
        logic [CELL_AW-1:0]  clr;
        logic                sel_b;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic              match_a;
        logic              match_b;
        logic [RCNT_W-1:0] used;
        logic              out_free;
    } dp_stat_t;

endpackage

/* rtl/cfpq_delta_closure_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CFPQ delta closure step
// Semi-naive closure engine for matrix-based context-free path querying.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the s_ stream: load rule, write cell, run step and
// read cell. Every accepted command produces exactly one transfer on the m_
// stream. The rule count register is written over the cfg channel, which is
// always ready and is meant to be written only while the block is idle.
// A run step first copies the stepped delta matrix, then fetches and checks
// each rule slot in use. For every rule whose right side names the stepped
// nonterminal it then computes each product: for each of the 32 rows a row
// fetch, a sweep over all 32 midpoints and a witness read-modify-write pass,
// then a merge. Finally it scans all delta rows for any_delta.
// One command is processed at a time; the result register lets the next
// command be accepted while the previous result still waits.
// After reset the block clears the witness store and both matrix memories,
// with s_tready low. If the receiver stalls, a finished result waits in the
// output register and the sequencer holds until it drains.
// ----------------------------------------------------------------------------
module cfpq_delta_closure_step (
    input  logic        aclk,
    input  logic        aresetn,
    // Command channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // nonterminal[3:0], row_vertex[8:4], col_vertex[13:9], rule_slot[19:14],
    // rule_left[23:20], rule_first[27:24], rule_second[31:28], path_in[32],
    // delta_in[33], terminal_mark[34], zero fill above.
    input  logic [39:0] s_tdata,
    // cmd[1:0].
    input  logic [1:0]  s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // path_out[0], delta_out[1], witness_kind[3:2], witness_mid[8:4],
    // witness_first[12:9], witness_second[16:13], any_delta[17], zero fill.
    output logic [23:0] m_tdata,
    // step_done[0].
    output logic [0:0]  m_tuser,
    // Rule count register write.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    cdcs_pkg::ctl_cmd_t ctl;
    cdcs_pkg::dp_stat_t stat;

    // The register is a plain flop, so a write is always taken at once.
    assign cfg_ready = 1'b1;

    cdcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    cdcs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* rtl/cdcs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CFPQ delta closure step: sequencer
// Walks reset clearing, cell access, the rule loop and the delta scan.
// ----------------------------------------------------------------------------
module cdcs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cdcs_pkg::dp_stat_t  stat,
    output cdcs_pkg::ctl_cmd_t  ctl
);

    typedef enum logic [19:0] {
        ST_CLEAR     = 20'h00001,
        ST_IDLE      = 20'h00002,
        ST_DISPATCH  = 20'h00004,
        ST_CELL_RD   = 20'h00008,
        ST_CELL_USE  = 20'h00010,
        ST_COPY_RD   = 20'h00020,
        ST_COPY_WR   = 20'h00040,
        ST_RULE_RD   = 20'h00080,
        ST_RULE_CHK  = 20'h00100,
        ST_ROW_RD    = 20'h00200,
        ST_ROW_LATCH = 20'h00400,
        ST_S_RD      = 20'h00800,
        ST_S_ACC     = 20'h01000,
        ST_W_RD      = 20'h02000,
        ST_W_WR      = 20'h04000,
        ST_MRG_RD    = 20'h08000,
        ST_MRG_WR    = 20'h10000,
        ST_SCAN_RD   = 20'h20000,
        ST_SCAN_ACC  = 20'h40000,
        ST_DONE      = 20'h80000
    } state_t;

    state_t                           state_reg, state_next;
    logic [cdcs_pkg::V_W-1:0]         row_reg, row_next;
    logic [cdcs_pkg::V_W-1:0]         mid_reg, mid_next;
    logic [cdcs_pkg::V_W-1:0]         col_reg, col_next;
    logic [cdcs_pkg::RCNT_W-1:0]      k_reg, k_next;
    logic [cdcs_pkg::ROW_AW-1:0]      scan_reg, scan_next;
    logic [cdcs_pkg::CELL_AW-1:0]     clr_reg, clr_next;
    logic                             sel_b_reg, sel_b_next;
    logic                             a_done_reg, a_done_next;
    cdcs_pkg::dp_op_t                 op;

    localparam logic [cdcs_pkg::V_W-1:0]     V_LAST    = '1;
    localparam logic [cdcs_pkg::ROW_AW-1:0]  SCAN_LAST = '1;
    localparam logic [cdcs_pkg::CELL_AW-1:0] CLR_LAST  = '1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            row_reg    <= '0;
            mid_reg    <= '0;
            col_reg    <= '0;
            k_reg      <= '0;
            scan_reg   <= '0;
            clr_reg    <= '0;
            sel_b_reg  <= 1'b0;
            a_done_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            mid_reg    <= mid_next;
            col_reg    <= col_next;
            k_reg      <= k_next;
            scan_reg   <= scan_next;
            clr_reg    <= clr_next;
            sel_b_reg  <= sel_b_next;
            a_done_reg <= a_done_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        row_next    = row_reg;
        mid_next    = mid_reg;
        col_next    = col_reg;
        k_next      = k_reg;
        scan_next   = scan_reg;
        clr_next    = clr_reg;
        sel_b_next  = sel_b_reg;
        a_done_next = a_done_reg;
        op          = cdcs_pkg::OP_NOP;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                op       = cdcs_pkg::OP_CLEAR;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op         = cdcs_pkg::OP_ACCEPT;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                row_next = '0;
                unique case (stat.cmd)
                    cdcs_pkg::CMD_LOAD: state_next = ST_DONE;
                    cdcs_pkg::CMD_RUN:  state_next = ST_COPY_RD;
                    default:            state_next = ST_CELL_RD;
                endcase
            end
            ST_CELL_RD: begin
                op         = cdcs_pkg::OP_CELL_RD;
                state_next = ST_CELL_USE;
            end
            ST_CELL_USE: begin
                op         = cdcs_pkg::OP_CELL_USE;
                state_next = ST_DONE;
            end
            ST_COPY_RD: begin
                op         = cdcs_pkg::OP_COPY_RD;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                op       = cdcs_pkg::OP_COPY_WR;
                row_next = row_reg + 1'b1;
                if (row_reg == V_LAST) begin
                    k_next      = '0;
                    a_done_next = 1'b0;
                    state_next  = ST_RULE_RD;
                end else begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_RULE_RD: begin
                if (k_reg == stat.used) begin
                    scan_next  = '0;
                    state_next = ST_SCAN_RD;
                end else begin
                    op         = cdcs_pkg::OP_RULE_RD;
                    state_next = ST_RULE_CHK;
                end
            end
            ST_RULE_CHK: begin
                row_next = '0;
                if (!a_done_reg && stat.match_a) begin
                    sel_b_next = 1'b0;
                    state_next = ST_ROW_RD;
                end else if (stat.match_b) begin
                    sel_b_next = 1'b1;
                    state_next = ST_ROW_RD;
                end else begin
                    k_next      = k_reg + 1'b1;
                    a_done_next = 1'b0;
                    state_next  = ST_RULE_RD;
                end
            end
            ST_ROW_RD: begin
                op         = cdcs_pkg::OP_ROW_RD;
                state_next = ST_ROW_LATCH;
            end
            ST_ROW_LATCH: begin
                op         = cdcs_pkg::OP_ROW_LATCH;
                mid_next   = '0;
                state_next = ST_S_RD;
            end
            ST_S_RD: begin
                op         = cdcs_pkg::OP_S_RD;
                state_next = ST_S_ACC;
            end
            ST_S_ACC: begin
                op       = cdcs_pkg::OP_S_ACC;
                mid_next = mid_reg + 1'b1;
                if (mid_reg == V_LAST) begin
                    col_next   = '0;
                    state_next = ST_W_RD;
                end else begin
                    state_next = ST_S_RD;
                end
            end
            ST_W_RD: begin
                op         = cdcs_pkg::OP_W_RD;
                state_next = ST_W_WR;
            end
            ST_W_WR: begin
                op       = cdcs_pkg::OP_W_WR;
                col_next = col_reg + 1'b1;
                if (col_reg == V_LAST) begin
                    row_next   = row_reg + 1'b1;
                    state_next = (row_reg == V_LAST) ? ST_MRG_RD : ST_ROW_RD;
                end else begin
                    state_next = ST_W_RD;
                end
            end
            ST_MRG_RD: begin
                op         = cdcs_pkg::OP_MRG_RD;
                state_next = ST_MRG_WR;
            end
            ST_MRG_WR: begin
                op       = cdcs_pkg::OP_MRG_WR;
                row_next = row_reg + 1'b1;
                if (row_reg == V_LAST) begin
                    if (!sel_b_reg) begin
                        a_done_next = 1'b1;
                        state_next  = ST_RULE_CHK;
                    end else begin
                        a_done_next = 1'b0;
                        k_next      = k_reg + 1'b1;
                        state_next  = ST_RULE_RD;
                    end
                end else begin
                    state_next = ST_MRG_RD;
                end
            end
            ST_SCAN_RD: begin
                op         = cdcs_pkg::OP_SCAN_RD;
                state_next = ST_SCAN_ACC;
            end
            ST_SCAN_ACC: begin
                op         = cdcs_pkg::OP_SCAN_ACC;
                scan_next  = scan_reg + 1'b1;
                state_next = (scan_reg == SCAN_LAST) ? ST_DONE : ST_SCAN_RD;
            end
            ST_DONE: begin
                op = cdcs_pkg::OP_DONE;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl.op        = op;
        ctl.row       = row_reg;
        ctl.mid       = mid_reg;
        ctl.col       = col_reg;
        ctl.rule_addr = k_reg[cdcs_pkg::SLOT_W-1:0];
        ctl.scan      = scan_reg;
        ctl.clr       = clr_reg;
        ctl.sel_b     = sel_b_reg;
    end

endmodule

/* rtl/cdcs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CFPQ delta closure step: datapath
// Matrix, witness and rule memories, product row unit and result register.
// ----------------------------------------------------------------------------
module cdcs_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  cdcs_pkg::ctl_cmd_t  ctl,
    output cdcs_pkg::dp_stat_t  stat,
    input  logic [39:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                cfg_valid,
    input  logic [6:0]          cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic [0:0]          m_tuser
);

    localparam int NV = cdcs_pkg::NUM_V;

    // Latched item.
    logic [1:0]                   cmd_reg;
    logic [cdcs_pkg::NT_W-1:0]    nt_reg;
    logic [cdcs_pkg::V_W-1:0]     row_reg;
    logic [cdcs_pkg::V_W-1:0]     col_reg;
    logic                         pin_reg, din_reg, tin_reg;

    logic [cdcs_pkg::RCNT_W-1:0]  rule_count_reg;

    cdcs_pkg::rule_t              rule_mem [cdcs_pkg::MAX_RULES];
    cdcs_pkg::rule_t              rule_q;

    logic [NV-1:0]                path_mem  [1 << cdcs_pkg::ROW_AW];
    logic [NV-1:0]                delta_mem [1 << cdcs_pkg::ROW_AW];
    cdcs_pkg::wit_t               wit_mem   [1 << cdcs_pkg::CELL_AW];
    logic [NV-1:0]                path_q, delta_q;
    cdcs_pkg::wit_t               wit_q;

    logic [NV-1:0]                delta_copy [NV];
    logic [NV-1:0]                prod_buf   [NV];
    logic [cdcs_pkg::V_W-1:0]     mid_arr    [NV];
    logic [NV-1:0]                a_row_reg, hit_reg;
    logic                         any_reg;

    logic                         st_path_reg, st_delta_reg;
    cdcs_pkg::wit_t               st_wit_reg;

    logic                         m_valid_reg;
    logic [23:0]                  m_data_reg;
    logic [0:0]                   m_user_reg;

    logic [cdcs_pkg::ROW_AW-1:0]  rd_addr;
    logic [cdcs_pkg::CELL_AW-1:0] wit_rd_addr;
    logic                         path_we, delta_we, wit_we;
    logic [cdcs_pkg::ROW_AW-1:0]  path_wa, delta_wa;
    logic [cdcs_pkg::CELL_AW-1:0] wit_wa;
    logic [NV-1:0]                path_wd, delta_wd;
    cdcs_pkg::wit_t               wit_wd;
    logic [NV-1:0]                col_oh, new_delta, b_row, dc_rd;
    logic [cdcs_pkg::V_W-1:0]     dc_idx;
    logic [cdcs_pkg::NT_W-1:0]    op_first, op_second;
    logic                         out_free;

    assign out_free  = !m_valid_reg || m_tready;
    assign col_oh    = NV'(1) << col_reg;
    assign op_first  = ctl.sel_b ? rule_q.first : nt_reg;
    assign op_second = ctl.sel_b ? nt_reg : rule_q.second;
    assign dc_idx    = (ctl.op == cdcs_pkg::OP_S_ACC) ? ctl.mid : ctl.row;
    assign dc_rd     = delta_copy[dc_idx];
    assign b_row     = ctl.sel_b ? dc_rd : path_q;
    assign new_delta = delta_q | (prod_buf[ctl.row] & ~path_q);

    always_comb begin
        stat.cmd      = cmd_reg;
        stat.match_a  = (rule_q.first == nt_reg);
        stat.match_b  = (rule_q.second == nt_reg);
        stat.used     = (rule_count_reg > cdcs_pkg::RULES_MAX) ? cdcs_pkg::RULES_MAX
                                                               : rule_count_reg;
        stat.out_free = out_free;
    end

    // Row read address shared by the path and delta memories.
    always_comb begin
        unique case (ctl.op)
            cdcs_pkg::OP_CELL_RD: rd_addr = {nt_reg, row_reg};
            cdcs_pkg::OP_COPY_RD: rd_addr = {nt_reg, ctl.row};
            cdcs_pkg::OP_ROW_RD:  rd_addr = {rule_q.first, ctl.row};
            cdcs_pkg::OP_S_RD:    rd_addr = {rule_q.second, ctl.mid};
            cdcs_pkg::OP_MRG_RD:  rd_addr = {rule_q.left, ctl.row};
            cdcs_pkg::OP_SCAN_RD: rd_addr = ctl.scan;
            default:              rd_addr = {nt_reg, ctl.row};
        endcase
        wit_rd_addr = (ctl.op == cdcs_pkg::OP_CELL_RD) ? {nt_reg, row_reg, col_reg}
                                                       : {rule_q.left, ctl.row, ctl.col};
    end

    always_comb begin
        path_we  = 1'b0;
        delta_we = 1'b0;
        wit_we   = 1'b0;
        path_wa  = {rule_q.left, ctl.row};
        delta_wa = {rule_q.left, ctl.row};
        wit_wa   = {rule_q.left, ctl.row, ctl.col};
        path_wd  = '0;
        delta_wd = '0;
        wit_wd   = '0;
        unique case (ctl.op)
            cdcs_pkg::OP_CLEAR: begin
                path_we  = 1'b1;
                delta_we = 1'b1;
                wit_we   = 1'b1;
                path_wa  = ctl.clr[cdcs_pkg::ROW_AW-1:0];
                delta_wa = ctl.clr[cdcs_pkg::ROW_AW-1:0];
                wit_wa   = ctl.clr;
            end
            cdcs_pkg::OP_CELL_USE: begin
                if (cmd_reg == cdcs_pkg::CMD_WRITE) begin
                    path_we     = 1'b1;
                    delta_we    = 1'b1;
                    wit_we      = 1'b1;
                    path_wa     = {nt_reg, row_reg};
                    delta_wa    = {nt_reg, row_reg};
                    wit_wa      = {nt_reg, row_reg, col_reg};
                    path_wd     = (path_q & ~col_oh) | (pin_reg ? col_oh : '0);
                    delta_wd    = (delta_q & ~col_oh) | (din_reg ? col_oh : '0);
                    wit_wd.kind = tin_reg ? cdcs_pkg::WK_TERM : cdcs_pkg::WK_UNSET;
                end
            end
            cdcs_pkg::OP_COPY_WR: begin
                delta_we = 1'b1;
                delta_wa = {nt_reg, ctl.row};
            end
            cdcs_pkg::OP_W_WR: begin
                wit_we        = hit_reg[ctl.col] && (wit_q.kind == cdcs_pkg::WK_UNSET);
                wit_wd.kind   = cdcs_pkg::WK_DERIVED;
                wit_wd.mid    = mid_arr[ctl.col];
                wit_wd.first  = op_first;
                wit_wd.second = op_second;
            end
            cdcs_pkg::OP_MRG_WR: begin
                path_we  = 1'b1;
                delta_we = 1'b1;
                path_wd  = path_q | new_delta;
                delta_wd = new_delta;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        path_q  <= path_mem[rd_addr];
        delta_q <= delta_mem[rd_addr];
        wit_q   <= wit_mem[wit_rd_addr];
        if (path_we) begin
            path_mem[path_wa] <= path_wd;
        end
        if (delta_we) begin
            delta_mem[delta_wa] <= delta_wd;
        end
        if (wit_we) begin
            wit_mem[wit_wa] <= wit_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.op == cdcs_pkg::OP_ACCEPT && s_tuser == cdcs_pkg::CMD_LOAD) begin
            rule_mem[s_tdata[19:14]] <= {s_tdata[23:20], s_tdata[27:24], s_tdata[31:28]};
        end
        if (ctl.op == cdcs_pkg::OP_RULE_RD) begin
            rule_q <= rule_mem[ctl.rule_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_count_reg <= '0;
        end else if (cfg_valid) begin
            rule_count_reg <= cfg_data;
        end
    end

    // Item capture, product row unit and result staging.
    always_ff @(posedge aclk) begin
        unique case (ctl.op)
            cdcs_pkg::OP_ACCEPT: begin
                cmd_reg      <= s_tuser;
                nt_reg       <= s_tdata[3:0];
                row_reg      <= s_tdata[8:4];
                col_reg      <= s_tdata[13:9];
                pin_reg      <= s_tdata[32];
                din_reg      <= s_tdata[33];
                tin_reg      <= s_tdata[34];
                any_reg      <= 1'b0;
                st_path_reg  <= 1'b0;
                st_delta_reg <= 1'b0;
                st_wit_reg   <= '0;
            end
            cdcs_pkg::OP_CELL_USE: begin
                if (cmd_reg == cdcs_pkg::CMD_READ) begin
                    st_path_reg  <= path_q[col_reg];
                    st_delta_reg <= delta_q[col_reg];
                    st_wit_reg   <= wit_q;
                end
            end
            cdcs_pkg::OP_COPY_WR: begin
                delta_copy[ctl.row] <= delta_q;
            end
            cdcs_pkg::OP_ROW_LATCH: begin
                a_row_reg <= ctl.sel_b ? path_q : dc_rd;
                hit_reg   <= '0;
            end
            cdcs_pkg::OP_S_ACC: begin
                if (a_row_reg[ctl.mid]) begin
                    for (int c = 0; c < NV; c++) begin
                        if (b_row[c] && !hit_reg[c]) begin
                            mid_arr[c] <= ctl.mid;
                        end
                    end
                    hit_reg <= hit_reg | b_row;
                end
            end
            cdcs_pkg::OP_W_WR: begin
                prod_buf[ctl.row] <= hit_reg;
            end
            cdcs_pkg::OP_SCAN_ACC: begin
                any_reg <= any_reg | (|delta_q);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.op == cdcs_pkg::OP_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.op == cdcs_pkg::OP_DONE && out_free) begin
            m_data_reg <= {6'd0, any_reg, st_wit_reg, st_delta_reg, st_path_reg};
            m_user_reg <= (cmd_reg == cdcs_pkg::CMD_RUN);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
